[rtl/jsu_pkg.sv]
// types, constants and helpers shared by the json string unescape block
// no dependencies
package jsu_pkg;

    localparam int unsigned FIFO_DEPTH = 4;

    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_LC_R = 8'h72;
    localparam logic [7:0] CH_LC_N = 8'h6E;
    localparam logic [7:0] CH_LC_T = 8'h74;
    localparam logic [7:0] CH_LC_B = 8'h62;
    localparam logic [7:0] CH_LC_F = 8'h66;
    localparam logic [7:0] CH_LC_U = 8'h75;
    localparam logic [7:0] CH_CR = 8'h0D;
    localparam logic [7:0] CH_LF = 8'h0A;
    localparam logic [7:0] CH_TAB = 8'h09;
    localparam logic [7:0] CH_BS = 8'h08;
    localparam logic [7:0] CH_FF = 8'h0C;

    localparam logic [2:0] HEX_DIGITS = 3'd4;

    typedef enum logic [2:0] {
        KIND_DATA    = 3'd0,
        KIND_END     = 3'd1,
        KIND_NOQUOTE = 3'd2,
        KIND_BADESC  = 3'd3,
        KIND_BADHEX  = 3'd4
    } t_kind;

    typedef enum logic [3:0] {
        MODE_WAIT = 4'b0001,
        MODE_BODY = 4'b0010,
        MODE_ESC  = 4'b0100,
        MODE_HEX  = 4'b1000
    } t_mode;

    // one queued job: one to three result bytes of a single input byte
    typedef struct packed {
        logic [1:0] count;
        t_kind      kind;
        logic [7:0] b0;
        logic [7:0] b1;
        logic [7:0] b2;
    } t_job;

    typedef struct packed {
        logic full;
        logic empty;
    } t_fifo_stat;

    // {valid, digit value}
    function automatic logic [4:0] hex_value(input logic [7:0] c);
        logic [4:0] r;
        r = 5'd0;
        if (c >= 8'h30 && c <= 8'h39) begin
            r = {1'b1, 4'(c - 8'h30)};
        end else if (c >= 8'h61 && c <= 8'h66) begin
            r = {1'b1, 4'(c - 8'h61 + 8'd10)};
        end else if (c >= 8'h41 && c <= 8'h46) begin
            r = {1'b1, 4'(c - 8'h41 + 8'd10)};
        end
        return r;
    endfunction

endpackage

[rtl/jsu_front.sv]
// front end: string parse state machine, builds result jobs
// depends on jsu_pkg
module jsu_front
    import jsu_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_accept,
    input  logic [7:0] i_byte,
    output logic       o_push,
    output t_job       o_job
);

    t_mode       r_mode, n_mode;
    logic [2:0]  r_hex_left, n_hex_left;
    logic [15:0] r_cp, n_cp;
    logic [4:0]  w_hex;
    logic [15:0] w_cp;
    logic        w_emit;
    t_job        w_job;

    assign w_hex = hex_value(i_byte);
    assign w_cp = {r_cp[11:0], w_hex[3:0]};

    always_comb begin
        n_mode = r_mode;
        n_hex_left = r_hex_left;
        n_cp = r_cp;
        w_emit = 1'b0;
        w_job.count = 2'd1;
        w_job.kind = KIND_DATA;
        w_job.b0 = 8'h00;
        w_job.b1 = 8'h00;
        w_job.b2 = 8'h00;
        case (r_mode)
            MODE_WAIT: begin
                if (i_byte == CH_QUOTE) begin
                    n_mode = MODE_BODY;
                end else begin
                    w_emit = 1'b1;
                    w_job.kind = KIND_NOQUOTE;
                end
            end
            MODE_BODY: begin
                if (i_byte == CH_QUOTE) begin
                    w_emit = 1'b1;
                    w_job.kind = KIND_END;
                    n_mode = MODE_WAIT;
                end else if (i_byte == CH_BSLASH) begin
                    n_mode = MODE_ESC;
                end else begin
                    w_emit = 1'b1;
                    w_job.b0 = i_byte;
                end
            end
            MODE_ESC: begin
                n_mode = MODE_BODY;
                w_emit = 1'b1;
                case (i_byte)
                    CH_BSLASH, CH_SLASH, CH_QUOTE: w_job.b0 = i_byte;
                    CH_LC_R: w_job.b0 = CH_CR;
                    CH_LC_N: w_job.b0 = CH_LF;
                    CH_LC_T: w_job.b0 = CH_TAB;
                    CH_LC_B: w_job.b0 = CH_BS;
                    CH_LC_F: w_job.b0 = CH_FF;
                    CH_LC_U: begin
                        w_emit = 1'b0;
                        n_mode = MODE_HEX;
                        n_hex_left = HEX_DIGITS;
                        n_cp = 16'h0000;
                    end
                    default: begin
                        w_job.kind = KIND_BADESC;
                        n_mode = MODE_WAIT;
                    end
                endcase
            end
            MODE_HEX: begin
                if (!w_hex[4]) begin
                    w_emit = 1'b1;
                    w_job.kind = KIND_BADHEX;
                    n_mode = MODE_WAIT;
                    n_hex_left = 3'd0;
                    n_cp = 16'h0000;
                end else begin
                    n_cp = w_cp;
                    n_hex_left = r_hex_left - 3'd1;
                    if (r_hex_left == 3'd1) begin
                        w_emit = 1'b1;
                        n_mode = MODE_BODY;
                        n_cp = 16'h0000;
                        if (w_cp < 16'h0080) begin
                            w_job.b0 = w_cp[7:0];
                        end else if (w_cp < 16'h0800) begin
                            w_job.count = 2'd2;
                            w_job.b0 = {3'b110, w_cp[10:6]};
                            w_job.b1 = {2'b10, w_cp[5:0]};
                        end else begin
                            w_job.count = 2'd3;
                            w_job.b0 = {4'b1110, w_cp[15:12]};
                            w_job.b1 = {2'b10, w_cp[11:6]};
                            w_job.b2 = {2'b10, w_cp[5:0]};
                        end
                    end
                end
            end
            default: begin
                n_mode = MODE_WAIT;
                n_hex_left = 3'd0;
                n_cp = 16'h0000;
            end
        endcase
    end

    assign o_push = i_accept && w_emit;
    assign o_job = w_job;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_WAIT;
            r_hex_left <= 3'd0;
            r_cp <= 16'h0000;
        end else if (i_accept) begin
            r_mode <= n_mode;
            r_hex_left <= n_hex_left;
            r_cp <= n_cp;
        end
    end

endmodule

[rtl/jsu_fifo.sv]
// job queue between the front end and the output sequencer
// depends on jsu_pkg
module jsu_fifo
    import jsu_pkg::*;
#(
    parameter int unsigned DEPTH = FIFO_DEPTH
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_push,
    input  t_job       i_job,
    input  logic       i_pop,
    output t_job       o_job,
    output t_fifo_stat o_stat
);

    localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = $clog2(DEPTH + 1);

    t_job           r_mem [DEPTH];
    logic [PW-1:0]  r_wr_ptr, r_rd_ptr;
    logic [CW-1:0]  r_count, n_count;
    logic           w_push, w_pop;

    assign o_stat.full = (r_count == CW'(DEPTH));
    assign o_stat.empty = (r_count == '0);
    assign w_push = i_push && !o_stat.full;
    assign w_pop = i_pop && !o_stat.empty;
    assign o_job = r_mem[r_rd_ptr];

    always_comb begin
        n_count = r_count;
        if (w_push && !w_pop) begin
            n_count = r_count + CW'(1);
        end else if (w_pop && !w_push) begin
            n_count = r_count - CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count <= '0;
        end else begin
            r_count <= n_count;
            if (w_push) begin
                r_wr_ptr <= (r_wr_ptr == PW'(DEPTH - 1)) ? '0 : r_wr_ptr + PW'(1);
            end
            if (w_pop) begin
                r_rd_ptr <= (r_rd_ptr == PW'(DEPTH - 1)) ? '0 : r_rd_ptr + PW'(1);
            end
        end
    end

endmodule

[rtl/jsu_back.sv]
// output sequencer: plays out one queued job, one result per transaction
// depends on jsu_pkg
module jsu_back
    import jsu_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_job       i_job,
    input  t_fifo_stat i_stat,
    output logic       o_pop,
    output logic       o_valid,
    input  logic       i_ready,
    output logic [7:0] o_byte,
    output t_kind      o_kind,
    output logic       o_last
);

    t_job       r_job;
    logic [1:0] r_idx;
    logic       r_busy;
    logic       w_done;

    assign o_valid = r_busy;
    assign o_last = ((r_idx + 2'd1) == r_job.count);
    assign o_kind = r_job.kind;
    assign w_done = r_busy && i_ready && o_last;
    assign o_pop = (!r_busy || w_done) && !i_stat.empty;

    always_comb begin
        case (r_idx)
            2'd0: o_byte = r_job.b0;
            2'd1: o_byte = r_job.b1;
            default: o_byte = r_job.b2;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_job <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_idx <= 2'd0;
        end else if (o_pop) begin
            r_busy <= 1'b1;
            r_idx <= 2'd0;
        end else if (w_done) begin
            r_busy <= 1'b0;
            r_idx <= 2'd0;
        end else if (r_busy && i_ready) begin
            r_idx <= r_idx + 2'd1;
        end
    end

endmodule

[rtl/json_string_unescape_utf8_top.sv]
// json string literal unescaper with utf-8 output for \u escapes
// input channel: one raw byte per transaction on i_in_valid / o_in_ready
// output channel: o_out_byte, o_kind, o_last on o_out_valid / i_out_ready
// kind 0 data byte, 1 string end, 2 no opening quote, 3 bad escape, 4 bad hex
// o_last marks the final result caused by one input byte
// a byte is accepted every cycle while the job queue has room
// a byte with results reaches the output through the job queue and then the sequencer's job register
// a \u escape gives up to three results, so the output rate, one result per
// cycle while the receiver is ready, is what bounds throughput
// when the receiver stalls the queue fills and o_in_ready drops
// reset empties the queue and returns the parser to waiting for a quote
// depends on jsu_pkg, jsu_front, jsu_fifo, jsu_back
module json_string_unescape_utf8_top
    import jsu_pkg::*;
#(
    parameter int unsigned FIFO_DEPTH_P = FIFO_DEPTH
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic [7:0] i_in_byte,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output logic [7:0] o_out_byte,
    output logic [2:0] o_kind,
    output logic       o_last
);

    logic       w_accept, w_push, w_pop;
    t_job       w_front_job, w_fifo_job;
    t_fifo_stat w_stat;
    t_kind      w_kind;

    assign o_in_ready = !w_stat.full;
    assign w_accept = i_in_valid && o_in_ready;
    assign o_kind = w_kind;

    jsu_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (w_accept),
        .i_byte   (i_in_byte),
        .o_push   (w_push),
        .o_job    (w_front_job)
    );

    jsu_fifo #(
        .DEPTH (FIFO_DEPTH_P)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_job   (w_front_job),
        .i_pop   (w_pop),
        .o_job   (w_fifo_job),
        .o_stat  (w_stat)
    );

    jsu_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_job   (w_fifo_job),
        .i_stat  (w_stat),
        .o_pop   (w_pop),
        .o_valid (o_out_valid),
        .i_ready (i_out_ready),
        .o_byte  (o_out_byte),
        .o_kind  (w_kind),
        .o_last  (o_last)
    );

    a_err_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (w_kind != KIND_DATA) |-> o_last && (o_out_byte == 8'h00))
        else $error("error or end result not single or carries data");

    a_multi_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_last |-> (w_kind == KIND_DATA))
        else $error("multi-result transaction of non-data kind");

    a_reset_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(!i_rst_n) |-> !o_out_valid && o_in_ready)
        else $error("block not idle after reset");

    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_push |-> !w_stat.full)
        else $error("job pushed into full queue");

endmodule
